FILE: design/skn_pkg.sv
`timescale 1ns / 1ps
package skn_pkg;

  // Default node capacity (entries per node)
  localparam int DefCapacity = 16;

  // Field widths
  localparam int KeyW   = 64;
  localparam int WordW  = 64;
  localparam int SlotW  = 4;
  localparam int CountW = 5;

  // Action codes carried on in_tuser
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } skn_act_t;

  // Status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } skn_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_PLACE,
    S_DEL_SHIFT,
    S_RD_WAIT,
    S_DONE
  } skn_state_t;

endpackage

FILE: design/sorted_key_node_insert_delete.sv
// Sorted key node: holds up to CAPACITY signed 64-bit keys in ascending order, each
// paired with a 64-bit word, in one single-port-read/single-port-write RAM with a
// registered read. Each input transaction yields exactly one result transaction. An
// insert walks the occupied entries from the top down, one entry per cycle, moving
// each larger-or-equal entry up by one until it finds the insertion point, then places
// the new entry and hands off the result. A delete moves the entries above the given
// position down, one per cycle; when the last entry goes, nothing moves. Rejected
// actions (full node, position not below the count, unused action code) go straight
// to the result. One transaction is worked on at a time; the result register lets a
// new input transaction be taken while the last result still waits.
`timescale 1ns / 1ps
module sorted_key_node_insert_delete #(
  parameter int CAPACITY = skn_pkg::DefCapacity
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: search_key[63:0], payload_word[127:64], slot_index[131:128], zero pad
  input  logic [135:0] in_tdata,
  // in_tuser: action[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: slot_used[3:0], entry_count[8:4], key_out[72:9], word_out[136:73], zero pad
  output logic [143:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready
);

  import skn_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > SlotW) ? CW : SlotW;
  localparam int PXW  = (AW > SlotW) ? AW : SlotW;
  localparam int CXW  = (CW > CountW) ? CW : CountW;
  localparam int EW   = KeyW + WordW;

  // Sequencer state
  skn_state_t state_r, state_nxt;

  // Node count and current transaction
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [KeyW-1:0]  key_r, key_nxt;
  logic [WordW-1:0]        word_r, word_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;

  // Read issue pointer and returned-data tracking
  logic [AW-1:0]           iss_r, iss_nxt;
  logic                    iss_en_r, iss_en_nxt;
  logic                    rv_r;
  logic [AW-1:0]           ra_r;

  // Result being built
  skn_status_t             res_status_r, res_status_nxt;
  logic [SlotW-1:0]        res_slot_r, res_slot_nxt;
  logic [KeyW-1:0]         res_key_r, res_key_nxt;
  logic [WordW-1:0]        res_word_r, res_word_nxt;

  // Output register
  logic                    out_tvalid_r, out_tvalid_nxt;
  skn_status_t             out_status_r;
  logic [SlotW-1:0]        out_slot_r;
  logic [CountW-1:0]       out_cnt_r;
  logic [KeyW-1:0]         out_key_r;
  logic [WordW-1:0]        out_word_r;

  // RAM port signals
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;
  logic signed [KeyW-1:0]  rd_key;

  // Decoded input
  logic                    in_fire;
  skn_act_t                in_act;
  logic [SlotW-1:0]        in_idx;
  logic [CMPW-1:0]         idx_w;
  logic                    idx_ok;
  logic [AW-1:0]           idx_a;
  logic [CW-1:0]           cnt_m1;
  logic                    cnt_full;
  logic                    scan_hit, scan_end, del_end, out_load;
  logic [PXW-1:0]          pos_x;
  logic [CXW-1:0]          cnt_x;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_act    = skn_act_t'(in_tuser);
  assign in_idx    = in_tdata[131:128];
  assign idx_w     = CMPW'(in_idx);
  assign idx_ok    = idx_w < CMPW'(cnt_r);
  assign idx_a     = idx_w[AW-1:0];
  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_full  = (cnt_r == CW'(CAPACITY));
  assign rd_key    = ram_rdata[KeyW-1:0];
  assign scan_hit  = rv_r && (rd_key < key_r);
  assign scan_end  = rv_r && (ra_r == '0);
  assign del_end   = rv_r && (ra_r == cnt_m1[AW-1:0]);
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign pos_x     = PXW'(pos_r);
  assign cnt_x     = CXW'(cnt_r);

  skn_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_INSERT: begin
              if (cnt_full) begin
                state_nxt = S_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                state_nxt = S_INS_SCAN;
              end
            end
            ACT_DELETE: begin
              if (!idx_ok || idx_a == cnt_m1[AW-1:0]) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_DEL_SHIFT;
              end
            end
            ACT_READ: begin
              state_nxt = idx_ok ? S_RD_WAIT : S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE:     state_nxt = S_DONE;
      S_DEL_SHIFT: begin
        if (del_end) begin
          state_nxt = S_DONE;
        end
      end
      S_RD_WAIT:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result fields
  always_comb begin
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    iss_nxt        = iss_r;
    iss_en_nxt     = iss_en_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    res_word_nxt   = res_word_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = iss_r;
    unique case (state_r)
      S_IDLE: begin
        // Capture the transaction and settle the trivial outcomes
        ram_raddr = idx_a;
        if (in_fire) begin
          key_nxt        = in_tdata[63:0];
          word_nxt       = in_tdata[127:64];
          pos_nxt        = '0;
          iss_en_nxt     = 1'b0;
          res_status_nxt = ST_DONE;
          res_slot_nxt   = '0;
          res_key_nxt    = '0;
          res_word_nxt   = '0;
          unique case (in_act)
            ACT_INSERT: begin
              if (cnt_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                iss_nxt    = cnt_m1[AW-1:0];
                iss_en_nxt = (cnt_r != '0);
              end
            end
            ACT_DELETE: begin
              res_slot_nxt = in_idx;
              if (!idx_ok) begin
                res_status_nxt = ST_RANGE;
              end else if (idx_a == cnt_m1[AW-1:0]) begin
                cnt_nxt = cnt_m1;
              end else begin
                iss_nxt    = idx_a + AW'(1);
                iss_en_nxt = 1'b1;
              end
            end
            ACT_READ: begin
              res_slot_nxt = in_idx;
              if (!idx_ok) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ram_re = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_SCAN: begin
        // Issue reads downward; move larger-or-equal entries up by one
        ram_re = iss_en_r;
        if (iss_r == '0) begin
          iss_en_nxt = 1'b0;
        end else begin
          iss_nxt = iss_r - AW'(1);
        end
        if (scan_hit) begin
          pos_nxt    = ra_r + AW'(1);
          iss_en_nxt = 1'b0;
        end else if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = ra_r + AW'(1);
          if (scan_end) begin
            pos_nxt = '0;
          end
        end
      end
      S_PLACE: begin
        // Write the new entry at its slot
        ram_we       = 1'b1;
        ram_waddr    = pos_r;
        ram_wdata    = {word_r, key_r};
        cnt_nxt      = cnt_r + CW'(1);
        res_slot_nxt = pos_x[SlotW-1:0];
      end
      S_DEL_SHIFT: begin
        // Issue reads upward; move each entry down by one
        ram_re = iss_en_r;
        if (iss_r == cnt_m1[AW-1:0]) begin
          iss_en_nxt = 1'b0;
        end else begin
          iss_nxt = iss_r + AW'(1);
        end
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = ra_r - AW'(1);
        end
        if (del_end) begin
          cnt_nxt = cnt_m1;
        end
      end
      S_RD_WAIT: begin
        res_key_nxt  = ram_rdata[KeyW-1:0];
        res_word_nxt = ram_rdata[EW-1:KeyW];
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register handshake
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      iss_en_r     <= 1'b0;
      rv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      iss_en_r     <= iss_en_nxt;
      rv_r         <= ram_re;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    word_r       <= word_nxt;
    pos_r        <= pos_nxt;
    iss_r        <= iss_nxt;
    ra_r         <= ram_raddr;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    res_word_r   <= res_word_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_cnt_r    <= cnt_x[CountW-1:0];
      out_key_r    <= res_key_r;
      out_word_r   <= res_word_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'b0, out_word_r, out_key_r, out_cnt_r, out_slot_r};

`ifndef SYNTH
  // Count never exceeds the node capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The shift never reads and writes the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write collide");

  // Placing an entry grows the count by exactly one
  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLACE |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the count");

  // An accepted transaction always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("accepted transaction dropped");
`endif

endmodule

FILE: design/skn_ram.sv
`timescale 1ns / 1ps
module skn_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
